>>> rtl/psr_pkg.sv
package psr_pkg;

  // Width of every index and colour field on the channels.
  localparam int FIELD_W = 8;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_ROT_LEFT  = 2'd1,
    CMD_ROT_RIGHT = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [FIELD_W-1:0] entry_index;
    logic [FIELD_W-1:0] red_in;
    logic [FIELD_W-1:0] green_in;
    logic [FIELD_W-1:0] blue_in;
    logic [FIELD_W-1:0] range_start;
    logic [FIELD_W-1:0] range_finish;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] red_out;
    logic [FIELD_W-1:0] green_out;
    logic [FIELD_W-1:0] blue_out;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ROTATE
  } state_t;

endpackage

>>> rtl/psr_ram.sv
module psr_ram import psr_pkg::*; #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  // An entry that has never been written since reset reads as zero, so the
  // array itself needs no clearing pass.
  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

>>> rtl/palette_store_with_rotate.sv
// Palette store with range rotate.
// One input channel (in_valid, in_stall, in_item) carries commands: write
// an entry, rotate a range of entries left or right by one place, or read
// an entry. Only a read gives an item on the result channel (out_valid,
// out_stall, out_item). An index or range at or above ENTRIES is ignored,
// and a read of such an index returns zero colours.
// A write goes into the palette memory at the edge that accepts it. A
// read first addresses the palette memory and then loads the output
// register once the receiver is free, which presents its result.
// During a rotate over start..finish, the separate read and write ports
// of the palette memory move one entry per cycle. in_stall is high while
// a read or a rotate is in progress.
// Reset (rst_n low, synchronous) empties the output register and marks
// every palette entry as unwritten, so all entries read as zero at once;
// no clearing pass is needed. If the receiver stalls, the result is held
// in the output register; a following read then waits until it is taken.
module palette_store_with_rotate import psr_pkg::*; #(
  parameter int ENTRIES        = 256,
  parameter int COMPONENT_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int              IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int              WORD_W = 3 * COMPONENT_BITS;
  localparam logic [FIELD_W:0] LIMIT = (FIELD_W + 1)'(ENTRIES);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic [IDX_W-1:0]   dst_r, dst_nxt;
  logic [IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [WORD_W-1:0]  tmp_r, tmp_nxt;
  logic               pend_r, pend_nxt;
  logic               first_r, first_nxt;
  logic               more_r, more_nxt;
  logic               left_r, left_nxt;
  logic               rd_zero_r, rd_zero_nxt;
  logic               out_valid_r;
  out_item_t          out_item_r;
  logic               out_load;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic               idx_ok;
  logic               rng_ok;
  logic               is_left;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   st_idx;
  logic [IDX_W-1:0]   fin_idx;
  logic [WORD_W-1:0]  rd_word;

  psr_ram #(
    .DEPTH  (ENTRIES),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign idx_ok  = {1'b0, in_item.entry_index} < LIMIT;
  assign rng_ok  = ({1'b0, in_item.range_start} < LIMIT) &&
                   ({1'b0, in_item.range_finish} < LIMIT);
  assign is_left = (in_item.command == CMD_ROT_LEFT);
  assign idx     = in_item.entry_index[IDX_W-1:0];
  assign st_idx  = in_item.range_start[IDX_W-1:0];
  assign fin_idx = in_item.range_finish[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      first_r <= 1'b0;
      more_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      first_r <= first_nxt;
      more_r  <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    last_r    <= last_nxt;
    dst_r     <= dst_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
    tmp_r     <= tmp_nxt;
    left_r    <= left_nxt;
    rd_zero_r <= rd_zero_nxt;
  end

  // The rotate streams through the memory: each cycle one entry is read
  // and the entry read in the cycle before is written one place over.
  // The first entry read is parked in tmp_r and written to the far end of
  // the range once the stream has drained. Reads always run ahead of the
  // writes in the direction of travel, so no read sees a stale entry.
  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    last_nxt    = last_r;
    dst_nxt     = dst_r;
    wr_ptr_nxt  = wr_ptr_r;
    tmp_nxt     = tmp_r;
    pend_nxt    = 1'b0;
    first_nxt   = first_r;
    more_nxt    = more_r;
    left_nxt    = left_r;
    rd_zero_nxt = rd_zero_r;
    in_stall    = 1'b1;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx;
    ram_wdata   = {in_item.red_in[COMPONENT_BITS-1:0],
                   in_item.green_in[COMPONENT_BITS-1:0],
                   in_item.blue_in[COMPONENT_BITS-1:0]};
    ram_re      = 1'b0;
    ram_raddr   = idx;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (in_item.command) inside
            CMD_WRITE: begin
              ram_we = idx_ok;
            end
            CMD_READ: begin
              ram_re      = idx_ok;
              rd_zero_nxt = !idx_ok;
              state_nxt   = ST_READ;
            end
            CMD_ROT_LEFT, CMD_ROT_RIGHT: begin
              if (rng_ok) begin
                ram_re     = 1'b1;
                ram_raddr  = is_left ? st_idx : fin_idx;
                pend_nxt   = 1'b1;
                first_nxt  = 1'b1;
                more_nxt   = in_item.range_start < in_item.range_finish;
                left_nxt   = is_left;
                ptr_nxt    = is_left ? st_idx + 1'b1 : fin_idx - 1'b1;
                last_nxt   = is_left ? fin_idx : st_idx;
                dst_nxt    = is_left ? fin_idx : st_idx;
                state_nxt  = ST_ROTATE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_ROTATE: begin
        if (pend_r) begin
          if (first_r) begin
            tmp_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_r;
            ram_wdata = ram_rdata;
          end
        end
        if (more_r) begin
          ram_re     = 1'b1;
          ram_raddr  = ptr_r;
          pend_nxt   = 1'b1;
          first_nxt  = 1'b0;
          wr_ptr_nxt = left_r ? ptr_r - 1'b1 : ptr_r + 1'b1;
          ptr_nxt    = left_r ? ptr_r + 1'b1 : ptr_r - 1'b1;
          more_nxt   = ptr_r != last_r;
        end else if (!pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = tmp_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // An out-of-range read returns zero colours.
  assign rd_word = rd_zero_r ? '0 : ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.red_out   <= FIELD_W'(rd_word[3*COMPONENT_BITS-1:2*COMPONENT_BITS]);
      out_item_r.green_out <= FIELD_W'(rd_word[2*COMPONENT_BITS-1:COMPONENT_BITS]);
      out_item_r.blue_out  <= FIELD_W'(rd_word[COMPONENT_BITS-1:0]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
